FILE: src/fpalu_pkg.sv
// Shared types, constants and helpers for the single-precision ALU.
package fpalu_pkg;

    localparam int unsigned WORD_W  = 32;
    localparam int unsigned CMD_W   = 3;
    localparam logic [31:0] CANON_NAN = 32'h7FC0_0000;

    typedef enum logic [2:0] {
        CMD_ADD = 3'd0,
        CMD_SUB = 3'd1,
        CMD_MUL = 3'd2,
        CMD_NEG = 3'd3,
        CMD_GT  = 3'd4,
        CMD_SHR = 3'd5
    } cmd_t;

    // Unpacked operand classification.
    typedef struct packed {
        logic       sign;
        logic [9:0] exp;
        logic [23:0] mant;
        logic       is_nan;
        logic       is_inf;
        logic       is_zero;
    } unp_t;

    function automatic unp_t unpack(input logic [31:0] w);
        unp_t u;
        u.sign    = w[31];
        u.exp     = (w[30:23] == 8'd0) ? 10'd1 : {2'b00, w[30:23]};
        u.mant    = {(w[30:23] != 8'd0), w[22:0]};
        u.is_nan  = (w[30:23] == 8'hFF) && (w[22:0] != 23'd0);
        u.is_inf  = (w[30:23] == 8'hFF) && (w[22:0] == 23'd0);
        u.is_zero = (w[30:0] == 31'd0);
        return u;
    endfunction

    // Count of leading zeros in a 28-bit word.
    function automatic logic [4:0] lzc28(input logic [27:0] v);
        logic [4:0] n;
        logic       found;
        n = 5'd28;
        found = 1'b0;
        for (int i = 27; i >= 0; i--) begin
            if (!found && v[i]) begin
                n = 5'(27 - i);
                found = 1'b1;
            end
        end
        return n;
    endfunction

    function automatic logic [5:0] lzc48(input logic [47:0] v);
        logic [5:0] n;
        logic       found;
        n = 6'd48;
        found = 1'b0;
        for (int i = 47; i >= 0; i--) begin
            if (!found && v[i]) begin
                n = 6'(47 - i);
                found = 1'b1;
            end
        end
        return n;
    endfunction

endpackage

FILE: src/fpalu_round.sv
// Final normalise-and-round stage body: takes a normalised significand and packs it.
module fpalu_round
    import fpalu_pkg::*;
(
    input  logic               sign,
    input  logic signed [11:0] exp_in,
    input  logic [26:0]        sig,
    output logic [31:0]        word
);
    // sig: bit 26 is the leading one (unless zero), bits 2:0 guard, round and sticky.
    logic signed [11:0] e;
    logic [5:0]         dsh;
    logic [26:0]        s2;
    logic               st;
    logic [24:0]        rnd;
    logic               inc;
    logic [7:0]         ef;

    always_comb
    begin
        e   = exp_in;
        s2  = sig;
        st  = 1'b0;
        dsh = 6'd0;
        if (e < 12'sd1) begin
            dsh = (e < -12'sd26) ? 6'd27 : 6'(12'sd1 - e);
            st  = |(sig & ((27'd1 << dsh) - 27'd1));
            s2  = sig >> dsh;
            e   = 12'sd0;
        end
        inc = s2[2] && (s2[1] || s2[0] || st || s2[3]);
        rnd = {1'b0, s2[26:3]} + {24'd0, inc};
        if (rnd[24]) begin
            e   = e + 12'sd1;
            rnd = rnd >> 1;
        end else if (e <= 12'sd1) begin
            // At the bottom of the range the exponent field is zero unless the hidden bit is set.
            e = rnd[23] ? 12'sd1 : 12'sd0;
        end
        ef = e[7:0];
        if (e >= 12'sd255)
            word = {sign, 8'hFF, 23'd0};
        else
            word = {sign, ef, rnd[22:0]};
    end
endmodule

FILE: src/fp32_alu.sv
// Top level of the pipelined single-precision floating-point ALU.
//
// One input channel carries an item of cmd, operand_a and operand_b; one
// output channel returns result_word. Both use a valid and ready handshake.
// Add, subtract, multiply and negate follow IEEE-754 binary32 with
// round-to-nearest-even and subnormals; every NaN result comes back as the
// canonical quiet NaN. Greater is an ordered compare giving 1 or 0, and
// shift right is logical, giving 0 for amounts of 32 or more. Unused codes
// give 0.
// The datapath has four register stages: operand alignment or the product,
// the add and normalisation count, the normalising shift, and rounding with
// an output register. One item is accepted in every cycle in which the
// output slot is free or its result is being taken.
// When the receiver stalls, all stages hold together: in_ready follows
// out_ready or an empty output slot, so nothing is lost or repeated, and
// the whole pipeline, bubbles included, stays frozen while the output waits.
// Reset clears every valid bit; the payload registers are not reset.
module fp32_alu
    import fpalu_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    output logic         in_ready,
    input  logic [2:0]   cmd,
    input  logic [31:0]  operand_a,
    input  logic [31:0]  operand_b,
    output logic         out_valid,
    input  logic         out_ready,
    output logic [31:0]  result_word
);
    // Per-stage payload.
    typedef struct packed {
        logic               special;     // result fully known
        logic [31:0]        sword;
        logic               is_mul;
        logic               sign;
        logic signed [11:0] exp;
        logic [47:0]        mag;         // product, or aligned addends
        logic [27:0]        addb;
        logic               sub;
    } st_t;

    logic v1_reg, v2_reg, v3_reg, v4_reg;
    st_t  s1_reg, s1_next, s2_reg, s2_next, s3_reg, s3_next;
    logic [31:0] r4_reg, r4_next;
    logic [5:0]  lz2_reg;
    logic        adv;

    // The whole pipe moves when the last slot is free or being taken.
    assign adv       = !v4_reg || out_ready;
    assign in_ready  = adv;
    assign out_valid = v4_reg;
    assign result_word = r4_reg;

    // Stage 1: classify, handle specials, align or multiply.
    unp_t ua, ub;
    logic bs;
    always_comb
    begin
        logic        eff_sub, swap;
        logic [9:0]  d;
        logic [27:0] mb, sh;
        logic        stk;
        logic [31:0] bb;
        unp_t        x, y;
        s1_next = '0;
        bb = (cmd == CMD_NEG) ? 32'hBF80_0000 : operand_b;
        ua = unpack(operand_a);
        ub = unpack(bb);
        bs = (cmd == CMD_SUB) ? ~ub.sign : ub.sign;
        eff_sub = 1'b0; swap = 1'b0; d = '0; mb = '0; sh = '0; stk = 1'b0;
        x = ua; y = ub;
        case (cmd)
            CMD_ADD, CMD_SUB:
            begin
                if (ua.is_nan || ub.is_nan || (ua.is_inf && ub.is_inf && ua.sign != bs)) begin
                    s1_next.special = 1'b1; s1_next.sword = CANON_NAN;
                end else if (ua.is_inf) begin
                    s1_next.special = 1'b1; s1_next.sword = {ua.sign, 8'hFF, 23'd0};
                end else if (ub.is_inf) begin
                    s1_next.special = 1'b1; s1_next.sword = {bs, 8'hFF, 23'd0};
                end else if (ua.is_zero && ub.is_zero) begin
                    s1_next.special = 1'b1; s1_next.sword = {ua.sign & bs, 31'd0};
                end else begin
                    x = ua; y = ub; y.sign = bs;
                    swap = {ub.exp, ub.mant} > {ua.exp, ua.mant};
                    if (swap) begin x = y; y = ua; end
                    eff_sub = x.sign != y.sign;
                    d  = x.exp - y.exp;
                    mb = {1'b0, y.mant, 3'b000};
                    if (d > 10'd27) begin
                        sh = '0; stk = |y.mant;
                    end else begin
                        sh  = mb >> d[4:0];
                        stk = |(mb & ((28'd1 << d[4:0]) - 28'd1));
                    end
                    s1_next.sign = x.sign;
                    s1_next.exp  = 12'(signed'({2'b00, x.exp}));
                    s1_next.mag  = {20'd0, 1'b0, x.mant, 3'b000};
                    s1_next.addb = {sh[27:1], sh[0] | stk};
                    s1_next.sub  = eff_sub;
                end
            end
            CMD_MUL, CMD_NEG:
            begin
                s1_next.is_mul = 1'b1;
                s1_next.sign = ua.sign ^ ub.sign;
                if (ua.is_nan || ub.is_nan || (ua.is_inf && ub.is_zero) ||
                    (ub.is_inf && ua.is_zero)) begin
                    s1_next.special = 1'b1; s1_next.sword = CANON_NAN;
                end else if (ua.is_inf || ub.is_inf) begin
                    s1_next.special = 1'b1; s1_next.sword = {ua.sign ^ ub.sign, 8'hFF, 23'd0};
                end else begin
                    s1_next.exp = 12'(signed'({2'b00, ua.exp})) +
                                  12'(signed'({2'b00, ub.exp})) - 12'sd126;
                    s1_next.mag = ua.mant * ub.mant;
                end
            end
            CMD_GT:
            begin
                s1_next.special = 1'b1;
                if (ua.is_nan || ub.is_nan || (ua.is_zero && ub.is_zero))
                    s1_next.sword = 32'd0;
                else if (!operand_a[31] && !bb[31])
                    s1_next.sword = {31'd0, operand_a[30:0] > bb[30:0]};
                else if (operand_a[31] && bb[31])
                    s1_next.sword = {31'd0, operand_a[30:0] < bb[30:0]};
                else
                    s1_next.sword = {31'd0, !operand_a[31]};
            end
            CMD_SHR:
            begin
                s1_next.special = 1'b1;
                s1_next.sword = (operand_b[31:5] != 27'd0) ? 32'd0 :
                                (operand_a >> operand_b[4:0]);
            end
            default:
            begin
                s1_next.special = 1'b1;
                s1_next.sword = 32'd0;
            end
        endcase
    end

    // Stage 2: add or subtract; count leading zeros.
    logic [5:0] lz_next;
    always_comb
    begin
        logic [27:0] sum;
        s2_next = s1_reg;
        sum = '0;
        if (!s1_reg.is_mul) begin
            sum = s1_reg.sub ? (s1_reg.mag[27:0] - s1_reg.addb)
                             : (s1_reg.mag[27:0] + s1_reg.addb);
            s2_next.mag = {sum, 20'd0};
            s2_next.exp = s1_reg.exp + 12'sd1;
        end
        lz_next = lzc48(s2_next.mag);
    end

    // Stage 3: normalising shift, limited so that it never takes the exponent below 1.
    always_comb
    begin
        logic [5:0]         lz;
        logic signed [11:0] room;
        logic [47:0]        m;
        s3_next = s2_reg;
        lz   = lz2_reg;
        room = s2_reg.exp - 12'sd1;
        if (room < 12'sd0)
            lz = 6'd0;
        else if (12'(signed'({6'd0, lz})) > room)
            lz = room[5:0];
        m = s2_reg.mag << lz;
        s3_next.mag = m;
        s3_next.exp = s2_reg.exp - 12'(signed'({6'd0, lz}));
        if (s2_reg.mag == 48'd0)
            s3_next.exp = 12'sd0;
    end

    // Stage 4: round and pack.
    logic [31:0] rw;
    logic        zr;
    fpalu_round u_round (
        .sign   (s3_reg.sign),
        .exp_in (s3_reg.exp),
        .sig    ({s3_reg.mag[47:22], |s3_reg.mag[21:0]}),
        .word   (rw)
    );
    always_comb
    begin
        zr = (s3_reg.mag == 48'd0);
        if (s3_reg.special)
            r4_next = s3_reg.sword;
        else if (zr)
            r4_next = {s3_reg.is_mul ? s3_reg.sign : 1'b0, 31'd0};
        else
            r4_next = rw;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            v1_reg <= 1'b0; v2_reg <= 1'b0; v3_reg <= 1'b0; v4_reg <= 1'b0;
        end else if (adv) begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv) begin
            s1_reg  <= s1_next;
            s2_reg  <= s2_next;
            lz2_reg <= lz_next;
            s3_reg  <= s3_next;
            r4_reg  <= r4_next;
        end
    end
endmodule
